@@ rtl/core/mnfvw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mnfvw_pkg: shared types, constants and microprogram
// Holds the microcode word layout, the control program and small lookup
// functions of the MIDI note to FM voice register writer.
// ---------------------------------------------------------------------------
package mnfvw_pkg;

   // voice table geometry
   localparam int VOICE_COUNT = 8;
   localparam int VOICE_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int NOTE_W      = 7;

   // operator levels
   localparam int LEVEL_W     = 7;
   localparam int LEVEL_COUNT = 4;
   localparam int CSR_IDX_W   = 2;

   typedef logic [LEVEL_COUNT-1:0][LEVEL_W-1:0] level_set_type;

   localparam logic [LEVEL_W-1:0] OP1_LEVEL_RESET = 7'd51;
   localparam logic [LEVEL_W-1:0] OP2_LEVEL_RESET = 7'd58;
   localparam logic [LEVEL_W-1:0] OP3_LEVEL_RESET = 7'd47;
   localparam logic [LEVEL_W-1:0] OP4_LEVEL_RESET = 7'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OP1_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OP2_LEVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OP3_LEVEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OP4_LEVEL = 2'd3;

   // synthesizer register map
   localparam logic [7:0] LEVEL_ADDR   = 8'h60;
   localparam logic [7:0] KEYCODE_ADDR = 8'h28;
   localparam logic [7:0] KEY_ADDR     = 8'h08;
   localparam logic [7:0] KEYON_MASK   = 8'h78;

   // MIDI message kinds (high nibble of status)
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

   // datapath operations
   localparam logic [3:0] OP_NONE        = 4'd0;
   localparam logic [3:0] OP_LOAD_STATUS = 4'd1;
   localparam logic [3:0] OP_LOAD_FIRST  = 4'd2;
   localparam logic [3:0] OP_CLR_COUNT   = 4'd3;
   localparam logic [3:0] OP_FIND_FREE   = 4'd4;
   localparam logic [3:0] OP_FIND_NOTE   = 4'd5;
   localparam logic [3:0] OP_CLAIM       = 4'd6;
   localparam logic [3:0] OP_RELEASE     = 4'd7;
   localparam logic [3:0] OP_KEYCODE     = 4'd8;

   // jump conditions
   localparam logic [2:0] C_NONE      = 3'd0;
   localparam logic [2:0] C_ALWAYS    = 3'd1;
   localparam logic [2:0] C_NO_ACCEPT = 3'd2;
   localparam logic [2:0] C_STATUS    = 3'd3;
   localparam logic [2:0] C_COUNT0    = 3'd4;
   localparam logic [2:0] C_KIND_OFF  = 3'd5;
   localparam logic [2:0] C_NOT_ON    = 3'd6;
   localparam logic [2:0] C_NO_HIT    = 3'd7;

   // output address and data selects
   localparam logic [1:0] AS_LEVEL   = 2'd0;
   localparam logic [1:0] AS_KEYCODE = 2'd1;
   localparam logic [1:0] AS_KEY     = 2'd2;

   localparam logic [1:0] DS_LEVEL   = 2'd0;
   localparam logic [1:0] DS_KEYCODE = 2'd1;
   localparam logic [1:0] DS_KEYON   = 2'd2;
   localparam logic [1:0] DS_VOICE   = 2'd3;

   // program steps
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
   localparam logic [PC_W-1:0] S_DECODE  = 5'd1;
   localparam logic [PC_W-1:0] S_COUNT   = 5'd2;
   localparam logic [PC_W-1:0] S_KIND    = 5'd3;
   localparam logic [PC_W-1:0] S_ONCHK   = 5'd4;
   localparam logic [PC_W-1:0] S_FREE    = 5'd5;
   localparam logic [PC_W-1:0] S_CLAIM   = 5'd6;
   localparam logic [PC_W-1:0] S_KC      = 5'd7;
   localparam logic [PC_W-1:0] S_LVL1    = 5'd8;
   localparam logic [PC_W-1:0] S_LVL2    = 5'd9;
   localparam logic [PC_W-1:0] S_LVL3    = 5'd10;
   localparam logic [PC_W-1:0] S_LVL4    = 5'd11;
   localparam logic [PC_W-1:0] S_KCODE   = 5'd12;
   localparam logic [PC_W-1:0] S_KEYON   = 5'd13;
   localparam logic [PC_W-1:0] S_FIND    = 5'd14;
   localparam logic [PC_W-1:0] S_RELEASE = 5'd15;
   localparam logic [PC_W-1:0] S_KEYOFF  = 5'd16;
   localparam logic [PC_W-1:0] S_STATUS  = 5'd17;
   localparam logic [PC_W-1:0] S_FIRST   = 5'd18;

   // one control word
   typedef struct packed {
      logic            emit;
      logic            last;
      logic [1:0]      addr_sel;
      logic [1:0]      data_sel;
      logic [1:0]      lvl;
      logic [3:0]      op;
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic is_status;
      logic count_zero;
      logic kind_off;
      logic not_on;
      logic no_hit;
      logic out_busy;
   } dp_status_type;

   function automatic ucode_type uword(input logic emit, input logic last,
                                       input logic [1:0] asel, input logic [1:0] dsel,
                                       input logic [1:0] lvl, input logic [3:0] op,
                                       input logic [2:0] cond,
                                       input logic [PC_W-1:0] target);
      ucode_type w;
      w.emit     = emit;
      w.last     = last;
      w.addr_sel = asel;
      w.data_sel = dsel;
      w.lvl      = lvl;
      w.op       = op;
      w.cond     = cond;
      w.target   = target;
      return w;
   endfunction

   // control program
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         S_IDLE:    w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_NONE,
                              C_NO_ACCEPT, S_IDLE);
         S_DECODE:  w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_NONE,
                              C_STATUS, S_STATUS);
         S_COUNT:   w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_NONE,
                              C_COUNT0, S_FIRST);
         S_KIND:    w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_CLR_COUNT,
                              C_KIND_OFF, S_FIND);
         S_ONCHK:   w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_NONE,
                              C_NOT_ON, S_IDLE);
         S_FREE:    w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_FIND_FREE,
                              C_NONE, S_IDLE);
         S_CLAIM:   w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_CLAIM,
                              C_NO_HIT, S_IDLE);
         S_KC:      w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_KEYCODE,
                              C_NONE, S_IDLE);
         S_LVL1:    w = uword(1'b1, 1'b0, AS_LEVEL, DS_LEVEL, 2'd0, OP_NONE,
                              C_NONE, S_IDLE);
         S_LVL2:    w = uword(1'b1, 1'b0, AS_LEVEL, DS_LEVEL, 2'd1, OP_NONE,
                              C_NONE, S_IDLE);
         S_LVL3:    w = uword(1'b1, 1'b0, AS_LEVEL, DS_LEVEL, 2'd2, OP_NONE,
                              C_NONE, S_IDLE);
         S_LVL4:    w = uword(1'b1, 1'b0, AS_LEVEL, DS_LEVEL, 2'd3, OP_NONE,
                              C_NONE, S_IDLE);
         S_KCODE:   w = uword(1'b1, 1'b0, AS_KEYCODE, DS_KEYCODE, 2'd0, OP_NONE,
                              C_NONE, S_IDLE);
         S_KEYON:   w = uword(1'b1, 1'b1, AS_KEY, DS_KEYON, 2'd0, OP_NONE,
                              C_ALWAYS, S_IDLE);
         S_FIND:    w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_FIND_NOTE,
                              C_NONE, S_IDLE);
         S_RELEASE: w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_RELEASE,
                              C_NO_HIT, S_IDLE);
         S_KEYOFF:  w = uword(1'b1, 1'b1, AS_KEY, DS_VOICE, 2'd0, OP_NONE,
                              C_ALWAYS, S_IDLE);
         S_STATUS:  w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_LOAD_STATUS,
                              C_ALWAYS, S_IDLE);
         S_FIRST:   w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_LOAD_FIRST,
                              C_ALWAYS, S_IDLE);
         default:   w = uword(1'b0, 1'b0, AS_KEY, DS_VOICE, 2'd0, OP_NONE,
                              C_ALWAYS, S_IDLE);
      endcase
      return w;
   endfunction

   // semitone code for note position within the octave
   function automatic logic [3:0] semitone_code(input logic [3:0] r);
      logic [3:0] c;
      case (r)
         4'd0:    c = 4'd13;
         4'd1:    c = 4'd14;
         4'd2:    c = 4'd0;
         4'd3:    c = 4'd1;
         4'd4:    c = 4'd2;
         4'd5:    c = 4'd3;
         4'd6:    c = 4'd5;
         4'd7:    c = 4'd6;
         4'd8:    c = 4'd7;
         4'd9:    c = 4'd9;
         4'd10:   c = 4'd10;
         4'd11:   c = 4'd11;
         default: c = 4'd0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/mnfvw_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mnfvw_seq: microprogram sequencer
// Step counter, control store lookup and conditional jump logic.
// ---------------------------------------------------------------------------
module mnfvw_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire mnfvw_pkg::dp_status_type status,
   output mnfvw_pkg::ucode_type         ctrl,
   output logic                         idle
);
   import mnfvw_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            taken;
   logic            stall;

   // control store
   assign ctrl = ucode_rom(pc_ff);
   assign idle = (pc_ff == S_IDLE);

   // jump condition select
   always_comb begin
      case (ctrl.cond)
         C_NONE:      taken = 1'b0;
         C_ALWAYS:    taken = 1'b1;
         C_NO_ACCEPT: taken = !accept;
         C_STATUS:    taken = status.is_status;
         C_COUNT0:    taken = status.count_zero;
         C_KIND_OFF:  taken = status.kind_off;
         C_NOT_ON:    taken = status.not_on;
         C_NO_HIT:    taken = status.no_hit;
         default:     taken = 1'b0;
      endcase
   end

   // an output step waits for room in the result register
   assign stall = ctrl.emit && status.out_busy;

   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // checks
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit && status.out_busy) |=> (pc_ff == $past(pc_ff)))
      else $error("output step advanced while result register was full");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      accept |=> (pc_ff == S_DECODE))
      else $error("accepted item not followed by decode step");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= S_FIRST)
      else $error("step counter left the program");

endmodule
`default_nettype wire

@@ rtl/core/mnfvw_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mnfvw_dp: datapath
// MIDI parse registers, voice table, key code unit and result register,
// all steered by the control word of the sequencer.
// ---------------------------------------------------------------------------
module mnfvw_dp (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [7:0]               in_byte,
   input  wire mnfvw_pkg::ucode_type     ctrl,
   input  wire mnfvw_pkg::level_set_type levels,
   output mnfvw_pkg::dp_status_type      status,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [15:0]                   rsp_tdata,
   output logic                          rsp_tlast
);
   import mnfvw_pkg::*;

   logic [7:0]                          byte_ff;
   logic [7:0]                          run_status_ff;
   logic                                count_ff;
   logic [NOTE_W-1:0]                   first_ff;
   logic [VOICE_COUNT-1:0][NOTE_W-1:0]  notes_ff;
   logic                                hit_ff;
   logic [VOICE_W-1:0]                  voice_ff;
   logic [7:0]                          kc_ff;
   logic                                out_valid_ff;
   logic [7:0]                          out_addr_ff;
   logic [7:0]                          out_data_ff;
   logic                                out_last_ff;

   logic [NOTE_W-1:0]  key;
   logic               found;
   logic [VOICE_W-1:0] found_idx;
   logic [7:0]         m;
   logic [15:0]        prod;
   logic [4:0]         q;
   logic [7:0]         r_full;
   logic [3:0]         r;
   logic [3:0]         oct;
   logic [4:0]         atten;
   logic [7:0]         level_sum;
   logic [7:0]         out_addr_in;
   logic [7:0]         out_data_in;
   logic               load_out;
   logic [3:0]         kind;

   // flags for the jump conditions
   assign kind = run_status_ff[7:4];
   always_comb begin
      status.is_status  = byte_ff[7];
      status.count_zero = !count_ff;
      status.kind_off   = (kind == KIND_NOTE_OFF) ||
                          ((kind == KIND_NOTE_ON) && (byte_ff == 8'd0));
      status.not_on     = (kind != KIND_NOTE_ON);
      status.no_hit     = !hit_ff;
      status.out_busy   = out_valid_ff && !rsp_tready;
   end

   // first voice holding the search key (zero means free)
   assign key = (ctrl.op == OP_FIND_FREE) ? '0 : first_ff;
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
         if (notes_ff[i] == key) begin
            found     = 1'b1;
            found_idx = VOICE_W'(i);
         end
      end
   end

   // key code: m = note + 21, q = m / 12 by reciprocal, r = m - 12q
   assign m      = 8'(first_ff) + 8'd21;
   assign prod   = 16'(m) * 16'd171;
   assign q      = prod[15:11];
   assign r_full = m - 8'({q, 3'b000}) - 8'({q, 2'b00});
   assign r      = r_full[3:0];
   assign oct    = 4'(q + 5'd13 - ((r < 4'd2) ? 5'd1 : 5'd0));

   // operator level with velocity attenuation
   assign atten     = 5'((7'd127 - byte_ff[6:0]) >> 2);
   assign level_sum = 8'(levels[ctrl.lvl]) + 8'(atten);

   // write address and data
   always_comb begin
      case (ctrl.addr_sel)
         AS_LEVEL:   out_addr_in = LEVEL_ADDR + 8'({ctrl.lvl, 3'b000}) + 8'(voice_ff);
         AS_KEYCODE: out_addr_in = KEYCODE_ADDR + 8'(voice_ff);
         default:    out_addr_in = KEY_ADDR;
      endcase
      case (ctrl.data_sel)
         DS_LEVEL:   out_data_in = level_sum;
         DS_KEYCODE: out_data_in = kc_ff;
         DS_KEYON:   out_data_in = KEYON_MASK + 8'(voice_ff);
         default:    out_data_in = 8'(voice_ff);
      endcase
   end

   assign load_out = ctrl.emit && !status.out_busy;

   // parse state and voice table
   always_ff @(posedge clock) begin
      if (reset) begin
         run_status_ff <= '0;
         count_ff      <= 1'b0;
         first_ff      <= '0;
         notes_ff      <= '0;
         hit_ff        <= 1'b0;
      end else begin
         case (ctrl.op)
            OP_LOAD_STATUS: begin
               run_status_ff <= byte_ff;
               count_ff      <= 1'b0;
            end
            OP_LOAD_FIRST: begin
               first_ff <= byte_ff[NOTE_W-1:0];
               count_ff <= 1'b1;
            end
            OP_CLR_COUNT: begin
               count_ff <= 1'b0;
            end
            OP_FIND_FREE, OP_FIND_NOTE: begin
               hit_ff <= found;
            end
            OP_CLAIM: begin
               if (hit_ff) begin
                  notes_ff[voice_ff] <= first_ff;
               end
            end
            OP_RELEASE: begin
               if (hit_ff) begin
                  notes_ff[voice_ff] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= in_byte;
      end
      if ((ctrl.op == OP_FIND_FREE) || (ctrl.op == OP_FIND_NOTE)) begin
         voice_ff <= found_idx;
      end
      if (ctrl.op == OP_KEYCODE) begin
         kc_ff <= {oct, semitone_code(r)};
      end
      if (load_out) begin
         out_addr_ff <= out_addr_in;
         out_data_ff <= out_data_in;
         out_last_ff <= ctrl.last;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_data_ff, out_addr_ff};
   assign rsp_tlast  = out_last_ff;

   // checks
   a_claim_free: assert property (@(posedge clock) disable iff (reset)
      ((ctrl.op == OP_CLAIM) && hit_ff) |-> (notes_ff[voice_ff] == '0))
      else $error("claimed voice was not free");

   a_last_is_key: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_addr_ff == KEY_ADDR))
      else $error("final write of an item is not a key write");

   a_emit_after_hit: assert property (@(posedge clock) disable iff (reset)
      load_out |-> hit_ff)
      else $error("write issued without a voice");

endmodule
`default_nettype wire

@@ rtl/core/midi_note_fm_voice_writer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// midi_note_fm_voice_writer_top: MIDI note to FM voice register writer
// Parses raw MIDI bytes, allocates voices and issues synthesizer writes.
// ---------------------------------------------------------------------------
// Throughput: one item at a time; the microprogram step counter sets the pace,
//    one control step per cycle while no output step waits on a full result register,
//    and one write per output step.
// Reset: synchronous; all voices free, running status and data count cleared,
//    operator levels back to 51, 58, 47, 2.
module midi_note_fm_voice_writer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // item in
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // midi_byte
   // result out
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [15:0]                          rsp_tdata,   // reg_address, reg_data
   output logic                                 rsp_tlast,   // last_write
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [mnfvw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mnfvw_pkg::LEVEL_W-1:0]   csr_wdata
);
   import mnfvw_pkg::*;

   level_set_type levels_ff;
   ucode_type     ctrl;
   dp_status_type status;
   logic          idle;
   logic          accept;

   // operator level registers
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff[CSR_OP1_LEVEL] <= OP1_LEVEL_RESET;
         levels_ff[CSR_OP2_LEVEL] <= OP2_LEVEL_RESET;
         levels_ff[CSR_OP3_LEVEL] <= OP3_LEVEL_RESET;
         levels_ff[CSR_OP4_LEVEL] <= OP4_LEVEL_RESET;
      end else if (csr_we) begin
         levels_ff[csr_index] <= csr_wdata;
      end
   end

   // input handshake
   assign req_tready = idle;
   assign accept     = req_tvalid && idle;

   mnfvw_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .ctrl   (ctrl),
      .idle   (idle)
   );

   mnfvw_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_tdata),
      .ctrl       (ctrl),
      .levels     (levels_ff),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ verif/voice_write_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// voice_write_checker: synthesizer write predictor and comparator
// Watches the MIDI byte, register write and level channels of the voice
// writer, works out the register writes each accepted byte should cause and
// compares every accepted write field by field against the oldest one due.
// ---------------------------------------------------------------------------
module voice_write_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [15:0]                     rsp_tdata,
   input  wire logic                            rsp_tlast,
   input  wire logic                            csr_we,
   input  wire logic [mnfvw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mnfvw_pkg::LEVEL_W-1:0]   csr_wdata,
   output int                                   fail_count,
   output int                                   pending_writes
);
   import mnfvw_pkg::*;

   // semitone code per position in the octave, position 0 in the low nibble
   localparam logic [47:0] SEMITONE_CODES = {4'd11, 4'd10, 4'd9, 4'd7, 4'd6, 4'd5,
                                             4'd3, 4'd2, 4'd1, 4'd0, 4'd14, 4'd13};

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
      logic       last;
   } synth_write_type;

   synth_write_type  expected_writes[$];
   logic [7:0]       run_status;
   logic             have_first;
   logic [NOTE_W-1:0] first_note;
   logic [NOTE_W-1:0] voice_note [VOICE_COUNT];
   logic [LEVEL_W-1:0] op_level  [LEVEL_COUNT];
   int               write_index;

   function automatic synth_write_type synth_write(input int addr, input int data,
                                                   input logic last);
      synth_write_type w;
      w.addr = addr[7:0];
      w.data = data[7:0];
      w.last = last;
      return w;
   endfunction

   // octave in the high nibble, semitone code in the low one
   function automatic logic [7:0] key_code(input logic [NOTE_W-1:0] note);
      int m;
      int q;
      int r;
      int oct;
      m   = int'(note) + 21;
      q   = m / 12;
      r   = m % 12;
      oct = (q + 13 - ((r < 2) ? 1 : 0)) & 15;
      return {oct[3:0], SEMITONE_CODES[r*4 +: 4]};
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] write %0d: %s", $realtime, write_index, what);
   endtask

   // parse one midi byte and queue the writes it causes
   task automatic predict_midi_byte(input logic [7:0] b);
      logic [3:0] kind;
      int         hit;
      int         atten;
      hit = -1;
      if (b[7]) begin
         run_status = b;
         have_first = 1'b0;
      end else if (!have_first) begin
         first_note = b[NOTE_W-1:0];
         have_first = 1'b1;
      end else begin
         have_first = 1'b0;
         kind       = run_status[7:4];
         if (kind == KIND_NOTE_ON && b != 8'd0) begin
            // note on: first free voice, levels, key code, key on
            for (int v = 0; v < VOICE_COUNT; v++)
               if (hit < 0 && voice_note[v] == '0) hit = v;
            if (hit >= 0) begin
               voice_note[hit] = first_note;
               atten = (127 - int'(b)) / 4;
               for (int k = 0; k < LEVEL_COUNT; k++)
                  expected_writes.push_back(synth_write(int'(LEVEL_ADDR) + 8*k + hit,
                                                        int'(op_level[k]) + atten, 1'b0));
               expected_writes.push_back(synth_write(int'(KEYCODE_ADDR) + hit,
                                                     int'(key_code(first_note)), 1'b0));
               expected_writes.push_back(synth_write(int'(KEY_ADDR),
                                                     int'(KEYON_MASK) + hit, 1'b1));
            end
         end else if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) begin
            // note off or zero velocity: first voice holding the note
            for (int v = 0; v < VOICE_COUNT; v++)
               if (hit < 0 && voice_note[v] == first_note) hit = v;
            if (hit >= 0) begin
               voice_note[hit] = '0;
               expected_writes.push_back(synth_write(int'(KEY_ADDR), hit, 1'b1));
            end
         end
      end
   endtask

   // track levels, predict on accepted bytes, compare accepted writes
   always @(posedge clock) begin
      synth_write_type got;
      synth_write_type want;
      if (reset) begin
         expected_writes.delete();
         fail_count  = 0;
         write_index = 0;
         run_status  = '0;
         have_first  = 1'b0;
         first_note  = '0;
         for (int v = 0; v < VOICE_COUNT; v++) voice_note[v] = '0;
         op_level[0] = OP1_LEVEL_RESET;
         op_level[1] = OP2_LEVEL_RESET;
         op_level[2] = OP3_LEVEL_RESET;
         op_level[3] = OP4_LEVEL_RESET;
      end else begin
         if (csr_we) op_level[csr_index] = csr_wdata;
         if (req_tvalid && req_tready) predict_midi_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.addr = rsp_tdata[7:0];
            got.data = rsp_tdata[15:8];
            got.last = rsp_tlast;
            if (expected_writes.size() == 0) begin
               report_mismatch($sformatf("unexpected write addr %02h data %02h",
                                         got.addr, got.data));
            end else begin
               want = expected_writes.pop_front();
               if (got.addr != want.addr)
                  report_mismatch($sformatf("reg_address %02h, want %02h",
                                            got.addr, want.addr));
               if (got.data != want.data)
                  report_mismatch($sformatf("reg_data %02h, want %02h",
                                            got.data, want.data));
               if (got.last != want.last)
                  report_mismatch($sformatf("last_write %0b, want %0b",
                                            got.last, want.last));
            end
            write_index++;
         end
      end
      pending_writes = expected_writes.size();
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: MIDI note to FM voice writer testbench
// Feeds directed and random MIDI byte streams under varying stalls and level
// settings; the checker predicts and compares the register writes.
// ---------------------------------------------------------------------------
module tb_top;
   import mnfvw_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 32;
   localparam int DRAIN_GUARD   = 20000;
   localparam int PHASE_BYTES   = 69;
   localparam int HOLD_CYCLES   = 250;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = 8'd0;   // midi_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;           // reg_address, reg_data
   logic                 rsp_tlast;           // last_write
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_OP1_LEVEL;
   logic [LEVEL_W-1:0]   csr_wdata  = '0;

   int          fail_count;
   int          pending_writes;
   int          cycle_count  = 0;
   int          send_idle_pct = 0;
   int          rcv_idle_pct  = 0;
   int          hold_token    = 0;
   int          hold_seen     = 0;
   int          hold_left     = 0;
   int          phase_bytes   = 0;
   logic        req_fire      = 1'b0;
   logic [7:0]  cur_status    = 8'd0;
   logic [6:0]  sounding[$];

   always #5 clock = ~clock;

   midi_note_fm_voice_writer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   voice_write_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_writes (pending_writes)
   );

   // input handshake seen at the edge, read by the sender at the falling edge
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("midi_note_fm_voice_writer_top test failed");
         $finish;
      end
   end

   // write receiver: random stalls, long hold-off on request
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen  <= hold_token;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // offer one item, with random gaps first; returns at the falling edge after accept
   task automatic send_midi(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      if (b[7]) cur_status = b;
      phase_bytes++;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic program_levels(input logic [LEVEL_W-1:0] l1, input logic [LEVEL_W-1:0] l2,
                                 input logic [LEVEL_W-1:0] l3, input logic [LEVEL_W-1:0] l4);
      csr_write(CSR_OP1_LEVEL, l1);
      csr_write(CSR_OP2_LEVEL, l2);
      csr_write(CSR_OP3_LEVEL, l3);
      csr_write(CSR_OP4_LEVEL, l4);
      csr_we <= 1'b0;
   endtask

   // wait for every predicted write, then let a message without writes finish
   task automatic wait_writes_drained();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_writes != 0 && guard < DRAIN_GUARD) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [6:0] pick_velocity();
      int p;
      p = $urandom_range(9);
      if (p == 0) return 7'd0;
      if (p == 1) return 7'd1;
      if (p == 2) return 7'd127;
      return 7'($urandom_range(127, 1));
   endfunction

   // one mostly well-formed message with random content, sometimes noise
   task automatic send_random_message();
      int         pick;
      int         slot;
      logic [6:0] note;
      logic [6:0] vel;
      pick = $urandom_range(99);
      if (pick < 55) begin
         // note on, often under running status
         if (cur_status[7:4] != KIND_NOTE_ON || $urandom_range(1) == 0)
            send_midi({KIND_NOTE_ON, 4'($urandom_range(15))});
         note = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127));
         vel  = pick_velocity();
         send_midi({1'b0, note});
         send_midi({1'b0, vel});
         if (vel != 0) sounding.push_back(note);
      end else if (pick < 85) begin
         // note off, mostly for a sounding note
         if (sounding.size() != 0 && $urandom_range(9) < 8) begin
            slot = $urandom_range(sounding.size() - 1);
            note = sounding[slot];
            sounding.delete(slot);
         end else begin
            note = 7'($urandom_range(127));
         end
         if ($urandom_range(1) == 0) begin
            send_midi({KIND_NOTE_OFF, 4'($urandom_range(15))});
            send_midi({1'b0, note});
            send_midi({1'b0, 7'($urandom_range(127))});
         end else begin
            send_midi({KIND_NOTE_ON, 4'($urandom_range(15))});
            send_midi({1'b0, note});
            send_midi(8'd0);
         end
      end else if (pick < 93) begin
         // message of some other kind
         send_midi({4'($urandom_range(15, 10)), 4'($urandom_range(15))});
         send_midi({1'b0, 7'($urandom_range(127))});
         send_midi({1'b0, 7'($urandom_range(127))});
      end else begin
         // stray byte, breaks message alignment
         send_midi(8'($urandom_range(255)));
      end
   endtask

   task automatic random_phase();
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_random_message();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      rcv_idle_pct  = 50;

      // data pair completed under the reset status
      send_midi(8'h00);
      send_midi(8'h7F);
      // note on, full velocity, then running status with the top note, velocity 1
      send_midi(8'h90);
      send_midi(8'd60);
      send_midi(8'd127);
      send_midi(8'd127);
      send_midi(8'd1);
      // note zero takes the first free voice but leaves it free
      send_midi(8'd0);
      send_midi(8'd64);
      // note off for note zero keys off that free voice
      send_midi(8'h85);
      send_midi(8'd0);
      send_midi(8'd0);
      // note on with zero velocity releases
      send_midi(8'h9F);
      send_midi(8'd60);
      send_midi(8'd0);
      // note off for a note nobody holds
      send_midi(8'h80);
      send_midi(8'd99);
      send_midi(8'h7F);
      // status in the middle of a message restarts the pair
      send_midi(8'hB3);
      send_midi(8'h12);
      send_midi(8'hFF);
      send_midi(8'h40);
      send_midi(8'h40);
      wait_writes_drained();

      // highest levels, overflow past 127
      program_levels(7'd127, 7'd127, 7'd127, 7'd127);
      random_phase();
      wait_writes_drained();

      // lowest levels, idling swapped
      program_levels(7'd0, 7'd0, 7'd0, 7'd0);
      send_idle_pct = 50;
      rcv_idle_pct  = 37;
      random_phase();
      wait_writes_drained();

      // random levels, no idling, long receiver hold-off at the start
      program_levels(7'($urandom_range(127)), 7'($urandom_range(127)),
                     7'($urandom_range(127)), 7'($urandom_range(127)));
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      hold_token <= hold_token + 1;
      random_phase();
      wait_writes_drained();

      if (fail_count == 0 && pending_writes == 0) begin
         $display("midi_note_fm_voice_writer_top test passed");
      end else begin
         $display("midi_note_fm_voice_writer_top test failed");
      end
      $finish;
   end

endmodule
